// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the stable priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   // request mode codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam int PRIO_W  = 16;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // one stored entry
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [VALUE_W-1:0] tag;
   } spq_entry_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic          occ;
      spq_entry_type entry;
   } spq_slot_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } spq_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: compare with the new word, keep or shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::spq_ctrl_type ctrl,
   input  spq_pkg::spq_entry_type new_entry,
   input  spq_pkg::spq_slot_type prev_slot,
   input  logic                  prev_ge,
   input  spq_pkg::spq_slot_type next_slot,
   input  logic                  shift_up,
   output spq_pkg::spq_slot_type slot,
   output logic                  ge,
   output logic                  match
);
   import spq_pkg::*;

   logic          occ_ff;
   logic          occ_in;
   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   assign ge    = occ_ff && ($signed(entry_ff.prio) >= $signed(new_entry.prio));
   assign match = occ_ff && (entry_ff.prio == new_entry.prio)
                         && (entry_ff.tag == new_entry.tag);

   always_comb begin
      occ_in   = occ_ff;
      entry_in = entry_ff;
      if (ctrl.ins && !ge) begin
         if (prev_ge) begin
            occ_in   = 1'b1;
            entry_in = new_entry;
         end else begin
            occ_in   = prev_slot.occ;
            entry_in = prev_slot.entry;
         end
      end else if (ctrl.rem && shift_up) begin
         occ_in   = next_slot.occ;
         entry_in = next_slot.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      entry_ff <= entry_in;
   end

   assign slot.occ   = occ_ff;
   assign slot.entry = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// sorted insert / matched remove queue built from a chain of compare cells
// ----------------------------------------------------------------------------
// the registered result word appears in the cycle after its request is taken
// throughput: one request word per cycle; every cell updates in that cycle
// the request side stalls only while a result word waits under rsp_stall
// reset empties the queue (cell occupancy and count) and drops any result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic signed [15:0]            req_entry_priority,
   input  logic [31:0]                   req_entry_value,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_success,
   output logic                          rsp_full_reject,
   output logic [spq_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                          rsp_head_valid,
   output logic signed [15:0]            rsp_head_priority,
   output logic [31:0]                   rsp_head_value
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LVLS  = $clog2(CAPACITY);

   // handshake
   logic accept;
   logic rsp_valid_ff, rsp_valid_in;
   logic success_ff, success_in;
   logic reject_ff, reject_in;

   // queue control
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;
   logic             do_insert;
   logic             do_remove;
   spq_ctrl_type     ctrl;
   spq_entry_type    new_entry;

   // cell row
   spq_slot_type          slot [CAPACITY];
   logic [CAPACITY-1:0]   ge;
   logic [CAPACITY-1:0]   match;
   logic [CAPACITY-1:0]   found;
   logic [CAPACITY-1:0]   pre [LVLS+1];
   logic [CNT_W+4:0]      count_ext;

   // a new word may enter whenever the result register is free or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign new_entry.prio = req_entry_priority;
   assign new_entry.tag  = req_entry_value;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign do_insert = accept && (req_mode == MODE_INSERT) && !full;
   // found[last] is set when any occupied cell matches
   assign do_remove = accept && (req_mode == MODE_REMOVE) && found[CAPACITY-1];

   assign ctrl.ins = do_insert;
   assign ctrl.rem = do_remove;

   // prefix or over the match bits: every cell from the first match onward
   // pulls its successor up; log-depth tree keeps the path short
   assign pre[0] = match;
   for (genvar lv = 0; lv < LVLS; lv++) begin : g_lvl
      for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
         if (i >= (1 << lv)) begin : g_or
            assign pre[lv+1][i] = pre[lv][i] | pre[lv][i - (1 << lv)];
         end else begin : g_pass
            assign pre[lv+1][i] = pre[lv][i];
         end
      end
   end
   assign found = pre[LVLS];

   // the chain: slot 0 is the head, slot CAPACITY-1 the tail
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_slot_type prev_s;
      spq_slot_type next_s;
      logic         prev_g;

      if (i == 0) begin : g_head
         assign prev_s = '0;
         assign prev_g = 1'b1;
      end else begin : g_mid
         assign prev_s = slot[i-1];
         assign prev_g = ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_s = '0;
      end else begin : g_body
         assign next_s = slot[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_entry (new_entry),
         .prev_slot (prev_s),
         .prev_ge   (prev_g),
         .next_slot (next_s),
         .shift_up  (found[i]),
         .slot      (slot[i]),
         .ge        (ge[i]),
         .match     (match[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      success_in   = success_ff;
      reject_in    = reject_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         success_in   = do_insert || do_remove;
         reject_in    = (req_mode == MODE_INSERT) && full;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      success_ff <= success_in;
      reject_ff  <= reject_in;
   end

   // the cell row cannot move while a result word is held, so the head and
   // count read straight from the state register
   assign count_ext = {5'b0, count_ff};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = success_ff;
   assign rsp_full_reject   = reject_ff;
   assign rsp_entry_count   = count_ext[COUNT_W-1:0];
   assign rsp_head_valid    = slot[0].occ;
   assign rsp_head_priority = slot[0].occ ? slot[0].entry.prio : '0;
   assign rsp_head_value    = slot[0].occ ? slot[0].entry.tag  : '0;

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_port_checks
// port level checks for the stable priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_port_checks (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_stall,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_success,
   input  logic        rsp_full_reject,
   input  logic [4:0]  rsp_entry_count,
   input  logic        rsp_head_valid,
   input  logic [15:0] rsp_head_priority,
   input  logic [31:0] rsp_head_value
);
   import spq_pkg::*;

   // no result word survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_success)
         && $stable(rsp_entry_count) && $stable(rsp_head_value))
      else $error("stalled result word changed");

   // a rejected insert is never a success and only happens with a head present
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_reject |-> !rsp_success && rsp_head_valid)
      else $error("full reject inconsistent");

   // empty queue shows a zero head
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> rsp_head_priority == 16'd0
         && rsp_head_value == 32'd0 && rsp_entry_count == 5'd0)
      else $error("empty queue shows nonzero head");

   // the result side alone decides stalls on the request side
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no held result word");

endmodule

bind stable_priority_queue spq_port_checks u_spq_port_checks (.*);

`default_nettype wire

// ===== verif/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// watches both channels of the stable priority queue, keeps its own copy of
// the sorted store and compares every result word against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_mode,
   input  logic signed [15:0]          req_entry_priority,
   input  logic [31:0]                 req_entry_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_success,
   input  logic                        rsp_full_reject,
   input  logic [spq_pkg::COUNT_W-1:0] rsp_entry_count,
   input  logic                        rsp_head_valid,
   input  logic signed [15:0]          rsp_head_priority,
   input  logic [31:0]                 rsp_head_value,
   output int                          fail_count,
   output int                          expected_left,
   output int                          words_checked,
   output int                          remove_hits,
   output int                          full_rejects
);

   typedef struct packed {
      logic                        success;
      logic                        full_reject;
      logic [spq_pkg::COUNT_W-1:0] entry_count;
      logic                        head_valid;
      logic signed [15:0]          head_priority;
      logic [31:0]                 head_value;
   } queue_answer_type;

   // shadow of the sorted store, head at index 0
   logic signed [15:0] shadow_prio [CAPACITY];
   logic [31:0]        shadow_tag  [CAPACITY];
   int                 shadow_fill;

   queue_answer_type answers_due[$];

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      if (fail_count < 40)
         $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
      fail_count++;
   endtask

   // sorted insert / first-match remove on the shadow store
   function automatic queue_answer_type apply_request(input logic mode,
                                                      input logic signed [15:0] prio,
                                                      input logic [31:0] tag);
      queue_answer_type ans;
      int               pos;
      int               i;
      ans = '0;
      pos = 0;
      if (mode == spq_pkg::MODE_INSERT) begin
         if (shadow_fill >= CAPACITY) begin
            ans.full_reject = 1'b1;
            full_rejects++;
         end else begin
            // equal priority goes behind, keeps arrival order
            while (pos < shadow_fill && shadow_prio[pos] >= prio)
               pos++;
            for (i = shadow_fill; i > pos; i--) begin
               shadow_prio[i] = shadow_prio[i-1];
               shadow_tag[i]  = shadow_tag[i-1];
            end
            shadow_prio[pos] = prio;
            shadow_tag[pos]  = tag;
            shadow_fill++;
            ans.success = 1'b1;
         end
      end else begin
         while (pos < shadow_fill && !(shadow_prio[pos] == prio && shadow_tag[pos] == tag))
            pos++;
         if (pos < shadow_fill) begin
            for (i = pos; i + 1 < shadow_fill; i++) begin
               shadow_prio[i] = shadow_prio[i+1];
               shadow_tag[i]  = shadow_tag[i+1];
            end
            shadow_fill--;
            ans.success = 1'b1;
            remove_hits++;
         end
      end
      ans.entry_count = shadow_fill[spq_pkg::COUNT_W-1:0];
      if (shadow_fill > 0) begin
         ans.head_valid    = 1'b1;
         ans.head_priority = shadow_prio[0];
         ans.head_value    = shadow_tag[0];
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      queue_answer_type want;
      if (reset) begin
         shadow_fill = 0;
         answers_due.delete();
      end else begin
         // result first: a word leaving now belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (answers_due.size() == 0) begin
               report_mismatch("result word with nothing expected", rsp_entry_count, 0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_success !== want.success)
                  report_mismatch("success", rsp_success, want.success);
               if (rsp_full_reject !== want.full_reject)
                  report_mismatch("full_reject", rsp_full_reject, want.full_reject);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, want.entry_count);
               if (rsp_head_valid !== want.head_valid)
                  report_mismatch("head_valid", rsp_head_valid, want.head_valid);
               if (rsp_head_priority !== want.head_priority)
                  report_mismatch("head_priority", rsp_head_priority, want.head_priority);
               if (rsp_head_value !== want.head_value)
                  report_mismatch("head_value", rsp_head_value, want.head_value);
            end
         end
         if (req_valid && !req_stall)
            answers_due.push_back(apply_request(req_mode, req_entry_priority,
                                                req_entry_value));
      end
      expected_left <= answers_due.size();
   end

endmodule

// ===== verif/tb_stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// drives inserts and removes into the stable priority queue with bursty
// request traffic and a stalling receiver; spq_checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stable_priority_queue;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_WORDS = 1627;
   localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
   localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
   localparam int DRAIN_CYCLES = 10;

   // receiver stall patterns
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_pattern_type;

   logic clock = 1'b0;
   logic reset;

   logic                        req_valid;
   logic                        req_stall;
   logic                        req_mode;
   logic signed [15:0]          req_entry_priority;
   logic [31:0]                 req_entry_value;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_success;
   logic                        rsp_full_reject;
   logic [spq_pkg::COUNT_W-1:0] rsp_entry_count;
   logic                        rsp_head_valid;
   logic signed [15:0]          rsp_head_priority;
   logic [31:0]                 rsp_head_value;

   int fail_count;
   int expected_left;
   int words_checked;
   int remove_hits;
   int full_rejects;

   // stimulus-side mirror of what is stored, so removes can aim at live entries
   logic signed [15:0] live_prio[$];
   logic [31:0]        live_tag[$];

   int inserts_sent;
   int removes_sent;
   int hold_asks;     // written by the sender only
   int idle_cycles;

   stable_priority_queue #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_entry_priority (req_entry_priority),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_full_reject    (rsp_full_reject),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_priority  (rsp_head_priority),
      .rsp_head_value     (rsp_head_value)
   );

   spq_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_entry_priority (req_entry_priority),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_full_reject    (rsp_full_reject),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_priority  (rsp_head_priority),
      .rsp_head_value     (rsp_head_value),
      .fail_count         (fail_count),
      .expected_left      (expected_left),
      .words_checked      (words_checked),
      .remove_hits        (remove_hits),
      .full_rejects       (full_rejects)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // priorities: extremes, a tight cluster around zero for ties, or anything
   function automatic logic signed [15:0] pick_priority();
      logic signed [15:0] p;
      case ($urandom_range(0, 9))
         0: p = 16'sh7FFF;
         1: p = 16'sh8000;
         2, 3, 4: begin
            p = 16'($urandom_range(0, 4));
            p = p - 16'sd2;
         end
         default: p = 16'($urandom());
      endcase
      return p;
   endfunction

   // tags: zero, all ones, a few small values for duplicates, or anything
   function automatic logic [31:0] pick_tag();
      logic [31:0] t;
      case ($urandom_range(0, 9))
         0:       t = 32'h0000_0000;
         1:       t = 32'hFFFF_FFFF;
         2, 3:    t = $urandom_range(0, 3);
         default: t = $urandom();
      endcase
      return t;
   endfunction

   // offer one word and hold it until the block takes it
   task automatic send_word(input logic mode, input logic signed [15:0] prio,
                            input logic [31:0] tag);
      int idx;
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_entry_priority <= prio;
      req_entry_value    <= tag;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      // keep the mirror in step: full inserts and missed removes change nothing
      if (mode == spq_pkg::MODE_INSERT) begin
         inserts_sent++;
         if (live_prio.size() < CAPACITY) begin
            live_prio.push_back(prio);
            live_tag.push_back(tag);
         end
      end else begin
         removes_sent++;
         for (idx = 0; idx < live_prio.size(); idx++) begin
            if (live_prio[idx] == prio && live_tag[idx] == tag) begin
               live_prio.delete(idx);
               live_tag.delete(idx);
               break;
            end
         end
      end
   endtask

   // mostly well-aimed removes; inserts now and then duplicate a live entry
   task automatic send_random_word(input int insert_pct);
      logic               mode;
      logic signed [15:0] prio;
      logic [31:0]        tag;
      int                 idx;
      bit                 reuse;
      mode = ($urandom_range(1, 100) <= insert_pct) ? spq_pkg::MODE_INSERT
                                                    : spq_pkg::MODE_REMOVE;
      if (mode == spq_pkg::MODE_REMOVE)
         reuse = ($urandom_range(0, 9) != 0);
      else
         reuse = ($urandom_range(0, 9) == 0);
      if (reuse && live_prio.size() != 0) begin
         idx  = $urandom_range(0, live_prio.size() - 1);
         prio = live_prio[idx];
         tag  = live_tag[idx];
      end else begin
         prio = pick_priority();
         tag  = pick_tag();
      end
      send_word(mode, prio, tag);
   endtask

   // receiver: changes stall pattern every so often, and serves long hold-offs
   initial begin
      stall_pattern_type pattern;
      int                pattern_left;
      int                holds_served;
      rsp_stall    <= 1'b0;
      pattern      = STALL_NONE;
      pattern_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_served) begin
            holds_served++;
            // hold the result side shut so the block backs up into the request side
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            if (pattern_left == 0) begin
               pattern      = stall_pattern_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (pattern)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
               default:      rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, expected_left);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // sender: reset, directed words, then bursty random traffic
   initial begin
      int i;
      int sent;
      int insert_pct;
      int seg_left;
      int burst_left;
      int gap;
      bit idle_free;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_mode           <= spq_pkg::MODE_INSERT;
      req_entry_priority <= '0;
      req_entry_value    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // remove from an empty store
      send_word(spq_pkg::MODE_REMOVE, 16'sd0, 32'h0000_0000);
      // value tag zero, then both priority extremes
      send_word(spq_pkg::MODE_INSERT, 16'sd0, 32'h0000_0000);
      send_word(spq_pkg::MODE_INSERT, 16'sh7FFF, 32'hFFFF_FFFF);
      send_word(spq_pkg::MODE_INSERT, 16'sh8000, 32'h0000_0000);
      // tie at the top must queue behind the earlier one
      send_word(spq_pkg::MODE_INSERT, 16'sh7FFF, 32'h0000_0001);
      // head removal hands the head to the tied entry
      send_word(spq_pkg::MODE_REMOVE, 16'sh7FFF, 32'hFFFF_FFFF);
      // remove with no match
      send_word(spq_pkg::MODE_REMOVE, 16'sd5, 32'h0000_0005);
      // fill up with runs of equal priority
      for (i = 0; i < CAPACITY - 3; i++)
         send_word(spq_pkg::MODE_INSERT, (i % 2) ? -16'sd1 : 16'sd1, i);
      // insert into a full store
      send_word(spq_pkg::MODE_INSERT, 16'sh7FFF, 32'h1234_5678);
      // remove from the middle and from the tail
      send_word(spq_pkg::MODE_REMOVE, 16'sd1, 32'h0000_0004);
      send_word(spq_pkg::MODE_REMOVE, 16'sh8000, 32'h0000_0000);

      // random part in segments with their own insert bias
      sent       = 0;
      burst_left = $urandom_range(1, 30);
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
         endcase
         seg_left  = $urandom_range(20, 80);
         idle_free = ($urandom_range(0, 3) == 0);
         while (seg_left > 0 && sent < RANDOM_WORDS) begin
            send_random_word(insert_pct);
            sent++;
            seg_left--;
            if (sent == 500 || sent == 1200) begin
               // long receiver hold-off while we keep offering back to back
               hold_asks  <= hold_asks + 1;
               burst_left = 40;
            end
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap = idle_free ? 0 : $urandom_range(0, 12);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      // all words in; let the results drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request words (%0d inserts, %0d removes), %0d receiver hold-offs",
               inserts_sent + removes_sent, inserts_sent, removes_sent, hold_asks);
      $display("checked %0d result words: %0d remove hits, %0d full rejects",
               words_checked, remove_hits, full_rejects);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
verif/spq_checker.sv
verif/tb_stable_priority_queue.sv
